// ----- rtl/aess_pkg.sv -----
// Package for the ADSR envelope sample scaler: widths, codes, config struct.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package aess_pkg;

    localparam int CHANNELS        = 2;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int LEVEL_W         = 24;
    localparam int FRAC_BITS       = 23;
    localparam int RECIP_W         = 33;
    localparam int CFG_DATA_W      = 33;
    localparam int CFG_IDX_W       = 3;
    localparam int OP_W            = 2;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'h800000;
    localparam logic [RECIP_W-1:0] RECIP_ONE  = 33'h1_0000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE   = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_STEP   = 3'd0,
        CFG_DECAY_STEP    = 3'd1,
        CFG_SUSTAIN_LEVEL = 3'd2,
        CFG_RELEASE_RECIP = 3'd3,
        CFG_RETRIGGER     = 3'd4,
        CFG_DECAY_ENABLED = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [RECIP_W-1:0] release_recip;
        logic               retrigger;
        logic               decay_enabled;
    } env_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/aess_env.sv -----
// Envelope state machine: phase, level and release step, advanced once per beat.
// Depends on aess_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aess_env
    import aess_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire env_cfg_t           cfg,
    input  wire logic               step,
    input  wire logic [OP_W-1:0]    op,
    output logic      [LEVEL_W-1:0] level,
    output logic                    done
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] rel_reg;
    logic [LEVEL_W-1:0] rel_next;

    logic [LEVEL_W-1:0]    sus;
    logic [LEVEL_W-1:0]    peak;
    logic [LEVEL_W:0]      atk_sum;
    logic                  atk_over;
    logic [LEVEL_W:0]      dec_diff;
    logic                  dec_under;
    logic                  rel_end;
    logic [LEVEL_W+31:0]   rel_prod;
    logic [LEVEL_W:0]      rel_sum;
    logic [LEVEL_W-1:0]    rel_sat;

    assign sus  = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;
    assign peak = cfg.decay_enabled ? FULL_SCALE : sus;

    assign atk_sum  = {1'b0, level_reg} + {1'b0, cfg.attack_step};
    assign atk_over = atk_sum > {1'b0, peak};

    assign dec_diff  = {1'b0, level_reg} - {1'b0, cfg.decay_step};
    assign dec_under = dec_diff[LEVEL_W] || (dec_diff[LEVEL_W-1:0] < sus);

    assign rel_end = level_reg <= rel_reg;

    // The 33-bit reciprocal is split into its fractional word and its integer bit.
    assign rel_prod = {{32{1'b0}}, level_reg}
                    * {{LEVEL_W{1'b0}}, cfg.release_recip[RECIP_W-2:0]};
    assign rel_sum  = {1'b0, rel_prod[LEVEL_W+31:32]}
                    + (cfg.release_recip[RECIP_W-1] ? {1'b0, level_reg} : {(LEVEL_W+1){1'b0}});
    assign rel_sat  = rel_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : rel_sum[LEVEL_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        case (op_t'(op))
            OP_NOTE_ON:
            begin
                phase_next = PH_ATTACK;
            end
            OP_NOTE_OFF:
            begin
                phase_next = PH_RELEASE;
            end
            OP_SAMPLE:
            begin
                unique case (phase_reg)
                    PH_ATTACK:
                    begin
                        if (atk_over)
                        begin
                            phase_next = cfg.decay_enabled ? PH_DECAY : PH_SUSTAIN;
                        end
                    end
                    PH_DECAY:
                    begin
                        if (dec_under)
                        begin
                            phase_next = PH_SUSTAIN;
                        end
                    end
                    PH_RELEASE:
                    begin
                        if (rel_end)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        level_next = level_reg;
        rel_next   = rel_reg;
        done       = 1'b0;
        case (op_t'(op))
            OP_NOTE_ON:
            begin
                if (cfg.retrigger)
                begin
                    level_next = '0;
                end
            end
            OP_NOTE_OFF:
            begin
                rel_next = rel_sat;
            end
            OP_SAMPLE:
            begin
                unique case (phase_reg)
                    PH_ATTACK:
                    begin
                        level_next = atk_over ? peak : atk_sum[LEVEL_W-1:0];
                    end
                    PH_DECAY:
                    begin
                        level_next = dec_under ? sus : dec_diff[LEVEL_W-1:0];
                    end
                    PH_RELEASE:
                    begin
                        level_next = rel_end ? '0 : (level_reg - rel_reg);
                        done       = rel_end;
                    end
                    PH_IDLE:
                    begin
                        level_next = '0;
                    end
                    default:
                    begin
                        level_next = sus;
                    end
                endcase
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    assign level = level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            level_reg <= '0;
            rel_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            rel_reg   <= rel_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/adsr_envelope_sample_scaler_core.sv -----
// Top level of the ADSR envelope sample scaler: config registers, pipeline, scaling.
// Depends on aess_pkg and aess_env.
//
//   channel   signals                                      direction
//   input     in_valid, in_stall, op, sample_left/right    beat in
//   output    out_valid, out_stall, out_left/right,
//             env_value, voice_done                        beat out
//   config    cfg_wr_en, cfg_index, cfg_data               write only
//
// One beat per cycle while no stall holds the pipeline; a sample beat is registered at each stage.
// The stages are the input register, the envelope update and the channel multipliers.
// Note beats update the envelope and give no result.
// Reset clears all valid flags, the envelope state and loads the config defaults.
// A stall on the output ripples back only through stages that hold a beat.
`timescale 1ns / 1ps
`default_nettype none
module adsr_envelope_sample_scaler_core
    import aess_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic        [OP_W-1:0]        op,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed      [SAMPLE_BITS-1:0] out_left,
    output logic signed      [SAMPLE_BITS-1:0] out_right,
    output logic             [LEVEL_W-1:0]     env_value,
    output logic                               voice_done,
    input  wire logic                          cfg_wr_en,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

    env_cfg_t cfg_reg;

    logic                          s1_valid_reg;
    logic [OP_W-1:0]               s1_op_reg;
    logic signed [SAMPLE_BITS-1:0] s1_smp_reg [CHANNELS];

    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_smp_reg [CHANNELS];
    logic [LEVEL_W-1:0]            s2_level_reg;
    logic                          s2_done_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_smp_reg [CHANNELS];
    logic [LEVEL_W-1:0]            out_level_reg;
    logic                          out_done_reg;

    logic                          ready_out;
    logic                          ready2;
    logic                          ready1;
    logic                          env_step;
    logic [LEVEL_W-1:0]            env_level;
    logic                          env_done;
    logic signed [SAMPLE_BITS-1:0] scaled [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_step   <= FULL_SCALE;
            cfg_reg.decay_step    <= '0;
            cfg_reg.sustain_level <= FULL_SCALE;
            cfg_reg.release_recip <= RECIP_ONE;
            cfg_reg.retrigger     <= 1'b0;
            cfg_reg.decay_enabled <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ATTACK_STEP:   cfg_reg.attack_step   <= cfg_data[LEVEL_W-1:0];
                CFG_DECAY_STEP:    cfg_reg.decay_step    <= cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL: cfg_reg.sustain_level <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_RECIP: cfg_reg.release_recip <= cfg_data[RECIP_W-1:0];
                CFG_RETRIGGER:     cfg_reg.retrigger     <= cfg_data[0];
                CFG_DECAY_ENABLED: cfg_reg.decay_enabled <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign ready_out = !out_valid_reg || !out_stall;
    assign ready2    = !s2_valid_reg || ready_out;
    assign ready1    = !s1_valid_reg || ready2;
    assign in_stall  = !ready1;
    assign env_step  = s1_valid_reg && ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg && (op_t'(s1_op_reg) == OP_SAMPLE);
            end
            if (ready_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            s1_op_reg     <= op;
            s1_smp_reg[0] <= sample_left;
            s1_smp_reg[1] <= sample_right;
        end
        if (env_step)
        begin
            s2_smp_reg   <= s1_smp_reg;
            s2_level_reg <= env_level;
            s2_done_reg  <= env_done;
        end
        if (s2_valid_reg && ready_out)
        begin
            out_smp_reg   <= scaled;
            out_level_reg <= s2_level_reg;
            out_done_reg  <= s2_done_reg;
        end
    end

    aess_env u_env
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (env_step),
        .op    (s1_op_reg),
        .level (env_level),
        .done  (env_done)
    );

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_lane
        logic signed [SAMPLE_BITS+LEVEL_W:0] prod;

        assign prod      = s2_smp_reg[g] * $signed({1'b0, s2_level_reg});
        assign scaled[g] = prod[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_smp_reg[0];
    assign out_right  = out_smp_reg[1];
    assign env_value  = out_level_reg;
    assign voice_done = out_done_reg;

endmodule
`default_nettype wire

// ----- rtl/aess_checker.sv -----
// Port-level checks for the ADSR envelope sample scaler, bound to the top level.
// Depends on aess_pkg and adsr_envelope_sample_scaler_core.
`timescale 1ns / 1ps
`default_nettype none
module aess_checker
    import aess_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic signed [SAMPLE_BITS-1:0] out_left,
    input wire logic signed [SAMPLE_BITS-1:0] out_right,
    input wire logic        [LEVEL_W-1:0]     env_value,
    input wire logic                          voice_done
);

    // A finished release always leaves the level at zero.
    a_done_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && voice_done) |-> (env_value == '0))
        else $error("voice_done with nonzero level");

    a_level_range : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (env_value <= FULL_SCALE))
        else $error("level above full scale");

    // A silent envelope must silence every channel.
    a_zero_mute : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (env_value == '0)) |-> ((out_left == '0) && (out_right == '0)))
        else $error("output nonzero at zero level");

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled beat dropped");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(out_left) && $stable(out_right)
                                      && $stable(env_value) && $stable(voice_done)))
        else $error("stalled beat changed");

endmodule

bind adsr_envelope_sample_scaler_core aess_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);
`default_nettype wire
